@@ hdl/assert_macros.svh @@
// assertion helpers shared by the rtl files
// each expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/mtbc_pkg.sv @@
`default_nettype none

package mtbc_pkg;

    localparam int MOM_W      = 16;
    localparam int TIME_W     = 16;
    localparam int ACC_W      = 48;
    localparam int HALF_W     = 24;
    localparam int PROD_W     = 40;
    localparam int FRAC_BITS  = 13;
    localparam int TIME_SHIFT = 22;
    localparam int NUM_COEF   = 10;
    localparam int NUM_STEPS  = NUM_COEF - 1;

    // raw momentum code of the 0.8 GeV break (0.8 * 8192 rounded up)
    localparam logic [MOM_W-1:0] MOM_BREAK = 16'd6554;

    // 2^32, scale of the Q16.32 coefficients
    localparam longint Q = 64'sd4294967296;

    typedef logic signed [ACC_W-1:0] acc_t;

    localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // one track moving down the pipeline with both running accumulators
    typedef struct packed {
        logic [MOM_W-1:0]         mom;
        logic signed [TIME_W-1:0] tdiff;
        logic                     high;
        acc_t                     up;
        acc_t                     dn;
    } item_t;

    // same track after the partial products of one horner step
    typedef struct packed {
        logic [MOM_W-1:0]         mom;
        logic signed [TIME_W-1:0] tdiff;
        logic                     high;
        logic signed [PROD_W-1:0] up_hi;
        logic [PROD_W-1:0]        up_lo;
        logic signed [PROD_W-1:0] dn_hi;
        logic [PROD_W-1:0]        dn_lo;
    } prod_t;

    typedef acc_t coef_arr_t [NUM_COEF];

    // coefficients by power of momentum, rounded half away from zero
    localparam coef_arr_t UPPER_LOW = '{
        acc_t'((120251 * Q + 500) / 1000),
        acc_t'(-((116819 * Q + 50) / 100)),
        acc_t'((523742 * Q + 50) / 100),
        acc_t'(-((136381 * Q + 5) / 10)),
        acc_t'((223253 * Q + 5) / 10),
        acc_t'(-((236496 * Q + 5) / 10)),
        acc_t'((161778 * Q + 5) / 10),
        acc_t'(-((689416 * Q + 50) / 100)),
        acc_t'((16634 * Q + 5) / 10),
        acc_t'(-((173474 * Q + 500) / 1000))
    };

    // degree-3 sets padded with zero leading terms
    localparam coef_arr_t UPPER_HIGH = '{
        acc_t'((159223 * Q + 50000) / 100000),
        acc_t'(-((149056 * Q + 50000) / 100000)),
        acc_t'((676338 * Q + 500000) / 1000000),
        acc_t'(-((104644 * Q + 500000) / 1000000)),
        '0, '0, '0, '0, '0, '0
    };

    localparam coef_arr_t LOWER_LOW = '{
        acc_t'(-((268257 * Q + 5000) / 10000)),
        acc_t'((153155 * Q + 500) / 1000),
        acc_t'(-((408979 * Q + 500) / 1000)),
        acc_t'((673476 * Q + 500) / 1000),
        acc_t'(-((790433 * Q + 500) / 1000)),
        acc_t'((708255 * Q + 500) / 1000),
        acc_t'(-((474843 * Q + 500) / 1000)),
        acc_t'((217295 * Q + 500) / 1000),
        acc_t'(-((586269 * Q + 5000) / 10000)),
        acc_t'((690981 * Q + 50000) / 100000)
    };

    localparam coef_arr_t LOWER_HIGH = '{
        acc_t'(-((11009 * Q + 5000) / 10000)),
        acc_t'((719988 * Q + 500000) / 1000000),
        acc_t'(-((280016 * Q + 500000) / 1000000)),
        acc_t'((319352 * Q + 5000000) / 10000000),
        '0, '0, '0, '0, '0, '0
    };

endpackage

`default_nettype wire

@@ hdl/mtbc_step.sv @@
`default_nettype none

`include "assert_macros.svh"

module mtbc_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  mtbc_pkg::item_t     in_item,
    output logic                in_ready,
    input  mtbc_pkg::acc_t      coef_low_up,
    input  mtbc_pkg::acc_t      coef_high_up,
    input  mtbc_pkg::acc_t      coef_low_dn,
    input  mtbc_pkg::acc_t      coef_high_dn,
    output logic                out_valid,
    output mtbc_pkg::item_t     out_item,
    input  logic                out_ready
);

    // signed upper half of the accumulator times momentum
    function automatic logic signed [mtbc_pkg::PROD_W-1:0] mul_hi(
        input mtbc_pkg::acc_t a,
        input logic [mtbc_pkg::MOM_W-1:0] m
    );
        logic signed [mtbc_pkg::PROD_W:0] p;
        p = $signed(a[mtbc_pkg::ACC_W-1:mtbc_pkg::HALF_W]) * $signed({1'b0, m});
        return p[mtbc_pkg::PROD_W-1:0];
    endfunction

    // unsigned lower half of the accumulator times momentum
    function automatic logic [mtbc_pkg::PROD_W-1:0] mul_lo(
        input mtbc_pkg::acc_t a,
        input logic [mtbc_pkg::MOM_W-1:0] m
    );
        logic [mtbc_pkg::PROD_W-1:0] p;
        p = a[mtbc_pkg::HALF_W-1:0] * m;
        return p;
    endfunction

    // floor(product / 2^13) + coefficient, saturated to 48 bits
    function automatic mtbc_pkg::acc_t horner_add(
        input logic signed [mtbc_pkg::PROD_W-1:0] hi,
        input logic [mtbc_pkg::PROD_W-1:0] lo,
        input mtbc_pkg::acc_t c
    );
        logic signed [52:0] s;
        s = $signed({{2{hi[mtbc_pkg::PROD_W-1]}}, hi, 11'b0})
            + $signed({26'b0, lo[mtbc_pkg::PROD_W-1:mtbc_pkg::FRAC_BITS]})
            + 53'(c);
        if (s > 53'(mtbc_pkg::ACC_MAX))
            return mtbc_pkg::ACC_MAX;
        else if (s < 53'(mtbc_pkg::ACC_MIN))
            return mtbc_pkg::ACC_MIN;
        else
            return s[mtbc_pkg::ACC_W-1:0];
    endfunction

    logic            mul_valid_reg;
    mtbc_pkg::prod_t mul_reg;
    mtbc_pkg::prod_t mul_next;
    logic            add_valid_reg;
    mtbc_pkg::item_t add_reg;
    mtbc_pkg::item_t add_next;
    logic            mul_en;
    logic            add_en;

    // a stage loads when empty or when its contents move on
    assign add_en   = !add_valid_reg || out_ready;
    assign mul_en   = !mul_valid_reg || add_en;
    assign in_ready = mul_en;

    // partial products for both bounds
    always_comb
    begin
        mul_next.mom   = in_item.mom;
        mul_next.tdiff = in_item.tdiff;
        mul_next.high  = in_item.high;
        mul_next.up_hi = mul_hi(in_item.up, in_item.mom);
        mul_next.up_lo = mul_lo(in_item.up, in_item.mom);
        mul_next.dn_hi = mul_hi(in_item.dn, in_item.mom);
        mul_next.dn_lo = mul_lo(in_item.dn, in_item.mom);
    end

    // recombine, scale and add the coefficient of the chosen set
    always_comb
    begin
        add_next.mom   = mul_reg.mom;
        add_next.tdiff = mul_reg.tdiff;
        add_next.high  = mul_reg.high;
        add_next.up    = horner_add(mul_reg.up_hi, mul_reg.up_lo,
                                    mul_reg.high ? coef_high_up : coef_low_up);
        add_next.dn    = horner_add(mul_reg.dn_hi, mul_reg.dn_lo,
                                    mul_reg.high ? coef_high_dn : coef_low_dn);
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            add_valid_reg <= 1'b0;
        end
        else
        begin
            if (mul_en)
                mul_valid_reg <= in_valid;
            if (add_en)
                add_valid_reg <= mul_valid_reg;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (mul_en)
            mul_reg <= mul_next;
        if (add_en)
            add_reg <= add_next;
    end

    assign out_valid = add_valid_reg;
    assign out_item  = add_reg;

    // a stalled result stays put until taken
    `ASSERT_NEXT(a_step_hold, add_valid_reg && !out_ready, add_valid_reg && $stable(add_reg))
    // a request accepted here lands in the product stage
    `ASSERT_NEXT(a_step_take, in_valid && in_ready, mul_valid_reg)

endmodule

`default_nettype wire

@@ hdl/mtbc_cmp.sv @@
`default_nettype none

`include "assert_macros.svh"

module mtbc_cmp (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  mtbc_pkg::item_t in_item,
    output logic            in_ready,
    output logic            out_valid,
    output logic            out_band,
    input  logic            out_ready
);

    logic           valid_reg;
    logic           band_reg;
    logic           band_next;
    logic           load;
    mtbc_pkg::acc_t tq;

    assign load     = !valid_reg || out_ready;
    assign in_ready = load;

    // time widened to Q16.32, then strict compare against both bounds
    always_comb
    begin
        tq        = mtbc_pkg::acc_t'($signed({in_item.tdiff,
                                             {mtbc_pkg::TIME_SHIFT{1'b0}}}));
        band_next = (tq > in_item.dn) && (tq < in_item.up);
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            band_reg <= band_next;
    end

    assign out_valid = valid_reg;
    assign out_band  = band_reg;

    // a result only appears after a request was handed over
    `ASSERT_SAME(a_cmp_source, $rose(valid_reg), $past(in_valid) && $past(in_ready))

endmodule

`default_nettype wire

@@ hdl/momentum_time_band_check.sv @@
// momentum-dependent time band check for one track per request
//
// input stream s_axis: tdata[15:0] momentum (unsigned Q3.13 GeV),
// tdata[31:16] time_diff (signed Q5.10 ns)
// output stream m_axis: tdata[0] in_band, tdata[7:1] zero
// in_band is 1 when the time lies strictly between a lower and an upper
// bound, each a polynomial in momentum (degree 9 below 0.8 GeV, degree 3
// at or above), evaluated by horner's rule in 48-bit Q16.32
//
// pipeline from accepted request to valid result: one entry
// stage, nine horner steps of two stages each - multiply, then add and
// saturate - and one compare/output stage
// one request per cycle unless stalled; every stage holds one track
// when m_axis_tready is low the output holds and stages behind it keep
// filling empty slots; s_axis_tready falls only once all 20 stages are full
// reset (rst_n low) empties every stage; no result is pending afterwards
`default_nettype none

`include "assert_macros.svh"

module momentum_time_band_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] momentum, [31:16] time_diff
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] in_band, [7:1] zero
);

    localparam int NS = mtbc_pkg::NUM_STEPS;

    logic            entry_valid_reg;
    mtbc_pkg::item_t entry_reg;
    mtbc_pkg::item_t entry_next;
    logic            entry_en;

    logic            step_valid [NS+1];
    mtbc_pkg::item_t step_item  [NS+1];
    logic            step_ready [NS+1];

    logic            band;

    // entry: pick the coefficient set and load the leading coefficients
    always_comb
    begin
        entry_next.mom   = s_axis_tdata[15:0];
        entry_next.tdiff = $signed(s_axis_tdata[31:16]);
        entry_next.high  = (s_axis_tdata[15:0] >= mtbc_pkg::MOM_BREAK);
        entry_next.up    = entry_next.high ? mtbc_pkg::UPPER_HIGH[NS]
                                           : mtbc_pkg::UPPER_LOW[NS];
        entry_next.dn    = entry_next.high ? mtbc_pkg::LOWER_HIGH[NS]
                                           : mtbc_pkg::LOWER_LOW[NS];
    end

    assign entry_en      = !entry_valid_reg || step_ready[0];
    assign s_axis_tready = entry_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_valid_reg <= 1'b0;
        else if (entry_en)
            entry_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (entry_en)
            entry_reg <= entry_next;
    end

    assign step_valid[0] = entry_valid_reg;
    assign step_item[0]  = entry_reg;

    // horner steps, highest power first
    for (genvar k = 0; k < NS; k++)
    begin : g_step
        mtbc_step u_step (
            .clk          (clk),
            .rst_n        (rst_n),
            .in_valid     (step_valid[k]),
            .in_item      (step_item[k]),
            .in_ready     (step_ready[k]),
            .coef_low_up  (mtbc_pkg::UPPER_LOW[NS-1-k]),
            .coef_high_up (mtbc_pkg::UPPER_HIGH[NS-1-k]),
            .coef_low_dn  (mtbc_pkg::LOWER_LOW[NS-1-k]),
            .coef_high_dn (mtbc_pkg::LOWER_HIGH[NS-1-k]),
            .out_valid    (step_valid[k+1]),
            .out_item     (step_item[k+1]),
            .out_ready    (step_ready[k+1])
        );
    end

    // bound compare and output register
    mtbc_cmp u_cmp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (step_valid[NS]),
        .in_item   (step_item[NS]),
        .in_ready  (step_ready[NS]),
        .out_valid (m_axis_tvalid),
        .out_band  (band),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {7'b0, band};

    // input back-pressure only comes from a stalled, completely full pipeline
    `ASSERT_SAME(a_top_full, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
    // an accepted request always lands in the entry stage
    `ASSERT_NEXT(a_top_entry, s_axis_tvalid && s_axis_tready, entry_valid_reg)

endmodule

`default_nettype wire
